// ===== sv/shi_pkg.sv =====
// shared types and constants for the safety interlock heartbeat block
`timescale 1ns / 1ps
`default_nettype none
package shi_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIME_W    = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LATENCY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_SILENCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEND_INTERVAL = 2'd2;

  localparam logic [CFG_W-1:0] MAX_LATENCY_RST   = 16'd50;
  localparam logic [CFG_W-1:0] MAX_SILENCE_RST   = 16'd500;
  localparam logic [CFG_W-1:0] SEND_INTERVAL_RST = 16'd100;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_STARTED = 2'd1,
    SEND_GO      = 2'd2,
    SEND_STOP    = 2'd3
  } send_code_t;

  typedef enum logic [1:0] {
    PH_SEND = 2'd0,
    PH_WAIT = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_latency_ms;
    logic [CFG_W-1:0] max_silence_ms;
    logic [CFG_W-1:0] send_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic ms_tick;
    logic estop_active;
    logic motor_fault_active;
    logic button_edge;
    logic confirm_received;
  } in_item_t;

  typedef struct packed {
    logic              drive_enable;
    send_code_t        send_code;
    logic              run_on;
    logic              startup_done;
    logic [TIME_W-1:0] latency_ms;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/shi_ifs.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface shi_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic estop_active;
  logic motor_fault_active;
  logic button_edge;
  logic confirm_received;

  modport source (output valid, output ms_tick, output estop_active,
                  output motor_fault_active, output button_edge,
                  output confirm_received, input ready);
  modport sink   (input valid, input ms_tick, input estop_active,
                  input motor_fault_active, input button_edge,
                  input confirm_received, output ready);
endinterface

interface shi_out_if;
  logic        valid;
  logic        ready;
  logic        drive_enable;
  logic [1:0]  send_code;
  logic        run_on;
  logic        startup_done;
  logic [31:0] latency_ms;

  modport source (output valid, output drive_enable, output send_code,
                  output run_on, output startup_done, output latency_ms,
                  input ready);
  modport sink   (input valid, input drive_enable, input send_code,
                  input run_on, input startup_done, input latency_ms,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/shi_in_reg.sv =====
// input register stage holding one request
`timescale 1ns / 1ps
`default_nettype none
module shi_in_reg
  import shi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          stage_valid,
  output in_item_t      stage_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule
`default_nettype wire

// ===== sv/shi_eval.sv =====
// one evaluation pass: handshake phases, run toggle, drive and heartbeat pacing
`timescale 1ns / 1ps
`default_nettype none
module shi_eval
  import shi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] sent_r, sent_nxt;
  logic [TIME_W-1:0] recv_r, recv_nxt;
  logic [TIME_W-1:0] lat_r, lat_nxt;
  logic              run_r, run_nxt;

  logic [TIME_W-1:0] d_sent;
  logic [TIME_W-1:0] d_recv;
  logic [TIME_W-1:0] lat_lim;
  logic [TIME_W-1:0] sil_lim;
  logic [TIME_W-1:0] int_lim;
  logic              run_tog;
  logic              lat_ok;
  logic              sil_ok;
  logic              drive;
  send_code_t        code;

  always_comb begin
    now_nxt = now_r + TIME_W'(item.ms_tick);
    d_sent  = now_nxt - sent_r;
    d_recv  = now_nxt - recv_r;
    lat_lim = TIME_W'(cfg.max_latency_ms);
    sil_lim = TIME_W'(cfg.max_silence_ms);
    int_lim = TIME_W'(cfg.send_interval_ms);

    phase_nxt = phase_r;
    sent_nxt  = sent_r;
    recv_nxt  = recv_r;
    lat_nxt   = lat_r;
    run_nxt   = run_r;
    code      = SEND_NONE;
    drive     = 1'b0;
    run_tog   = run_r ^ (item.button_edge && !item.estop_active);
    // a confirmation in this pass replaces the stored latency before the check
    lat_ok    = item.confirm_received ? (d_sent <= lat_lim) : (lat_r <= lat_lim);
    sil_ok    = item.confirm_received || (d_recv <= sil_lim);

    unique case (phase_r)
      PH_SEND: begin
        code      = SEND_STARTED;
        sent_nxt  = now_nxt;
        phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        if (item.confirm_received || (d_sent > sil_lim)) begin
          lat_nxt = d_sent;
          if (d_sent > lat_lim) begin
            code     = SEND_STARTED;
            sent_nxt = now_nxt;
          end else begin
            phase_nxt = PH_RUN;
          end
        end
      end
      default: begin
        if (item.confirm_received) begin
          recv_nxt = now_nxt;
          lat_nxt  = d_sent;
        end
        if (!item.estop_active && !item.motor_fault_active && lat_ok && sil_ok &&
            run_tog) begin
          drive   = 1'b1;
          run_nxt = run_tog;
          if (d_sent >= int_lim) begin
            code     = SEND_GO;
            sent_nxt = now_nxt;
          end
        end else begin
          run_nxt = 1'b0;
          if (d_sent > int_lim) begin
            code     = SEND_STOP;
            sent_nxt = now_nxt;
          end
        end
      end
    endcase

    result.drive_enable = drive;
    result.send_code    = code;
    result.run_on       = run_nxt;
    result.startup_done = (phase_nxt != PH_SEND) && (phase_nxt != PH_WAIT);
    result.latency_ms   = lat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEND;
      now_r   <= '0;
      sent_r  <= '0;
      recv_r  <= '0;
      lat_r   <= '0;
      run_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      now_r   <= now_nxt;
      sent_r  <= sent_nxt;
      recv_r  <= recv_nxt;
      lat_r   <= lat_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/safety_interlock_heartbeat.sv =====
// safety interlock heartbeat: top level with config registers and result register
// an accepted request waits in the input register, and its result is then loaded into the result register
// throughput: one request per cycle; a held result register stalls the input register
// the pass is one stage of wrapping subtracts and compares on the state registers
// reset (synchronous, rst_n low): time, handshake phase, run and latency state cleared,
// config registers back to 50 / 500 / 100 ms, both channels empty
`timescale 1ns / 1ps
`default_nettype none
module safety_interlock_heartbeat
  import shi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  shi_in_if.sink                    in_ch,
  shi_out_if.source                 out_ch
);

  cfg_t      cfg_r;
  in_item_t  in_item;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      advance;
  logic      in_ready;
  out_item_t result;
  out_item_t out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_latency_ms   <= MAX_LATENCY_RST;
      cfg_r.max_silence_ms   <= MAX_SILENCE_RST;
      cfg_r.send_interval_ms <= SEND_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MAX_LATENCY:   cfg_r.max_latency_ms   <= cfg_wdata;
        CFG_IDX_MAX_SILENCE:   cfg_r.max_silence_ms   <= cfg_wdata;
        CFG_IDX_SEND_INTERVAL: cfg_r.send_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_item.ms_tick            = in_ch.ms_tick;
  assign in_item.estop_active       = in_ch.estop_active;
  assign in_item.motor_fault_active = in_ch.motor_fault_active;
  assign in_item.button_edge        = in_ch.button_edge;
  assign in_item.confirm_received   = in_ch.confirm_received;
  assign in_ch.ready                = in_ready;

  // request moves on when the result register is empty or being drained
  assign advance = stage_valid && (!out_valid_r || out_ch.ready);

  shi_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  shi_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (stage_item),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_enable = out_r.drive_enable;
  assign out_ch.send_code    = 2'(out_r.send_code);
  assign out_ch.run_on       = out_r.run_on;
  assign out_ch.startup_done = out_r.startup_done;
  assign out_ch.latency_ms   = out_r.latency_ms;

  a_drive_needs_startup: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.drive_enable |-> out_ch.startup_done && out_ch.run_on)
    else $error("drive enabled before startup or with run off");

  a_run_off_in_startup: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.startup_done |-> !out_ch.run_on && !out_ch.drive_enable)
    else $error("run set during startup handshake");

  a_go_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.send_code == SEND_GO) |-> out_ch.drive_enable)
    else $error("go message while drive disabled");

  a_stop_only_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.send_code == SEND_STOP) |-> !out_ch.drive_enable)
    else $error("stop message while drive enabled");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("held request lost or changed in input stage");

endmodule
`default_nettype wire
